### design/rgbypb_pkg.sv
// shared types, constants and coefficient tables for the bt.601 rgb/ypbpr converter
// no dependencies; imported by every other module of the block
package rgbypb_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int NCH        = 3;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SAMPLE = 1'b1;

  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_REV = 1'b1;

  // coefficients are scaled by 1e6
  localparam int COEF_W = 22;

  // forward: rows are y, pb, pr; columns are r, g, b
  localparam logic signed [COEF_W-1:0] FWD_COEF [NCH][NCH] = '{
    '{ 22'sd299000,  22'sd587000,  22'sd114000},
    '{-22'sd168736, -22'sd331264,  22'sd500000},
    '{ 22'sd500000, -22'sd418688, -22'sd81312}
  };

  // reverse matrix terms
  localparam logic signed [COEF_W-1:0] K_Y  = 22'sd1000000;
  localparam logic signed [COEF_W-1:0] K_RV = 22'sd1402000;
  localparam logic signed [COEF_W-1:0] K_GU = 22'sd344136;
  localparam logic signed [COEF_W-1:0] K_GV = 22'sd714136;
  localparam logic signed [COEF_W-1:0] K_BU = 22'sd1772000;

  // forward arithmetic: q = (|n|*512 + 15625*d) / (31250*d)
  localparam int FWD_W     = 38;
  localparam int REM_W     = 48;
  localparam int QUO_W     = 17;
  localparam int NUM_SHIFT = 9;
  localparam int DEN_W     = 31;
  localparam int HALF_W    = 30;
  localparam logic [DEN_W-1:0]  DEN_MUL  = 31'd31250;
  localparam logic [HALF_W-1:0] HALF_MUL = 30'd15625;
  localparam logic [QUO_W-1:0]  SAT_POS  = 17'd32767;
  localparam logic [QUO_W-1:0]  SAT_NEG  = 17'd32768;

  // reverse arithmetic: clamp to 2^14*1e6, scale by d, divide by 2^20 then by 15625
  localparam int REV_W       = 38;
  localparam int CLAMP_W     = 34;
  localparam logic [CLAMP_W-1:0] FULL_SCALE = 34'd16384000000;
  localparam int SCL_W       = 50;
  localparam int PRE_SHIFT   = 20;
  localparam int X_W         = 30;
  localparam int RCP_W       = 61;
  localparam logic [RCP_W-1:0] RECIP = 61'd1125899907;
  localparam int RECIP_SHIFT = 44;

  // pipeline depth
  localparam int DIV_FIRST  = 4;
  localparam int FWD_STAGES = QUO_W + 5;
  localparam int REV_CORE   = 4;
  localparam int DLY_N      = FWD_STAGES - REV_CORE + 1;
  localparam int NSTG       = FWD_STAGES + 1;

  // reset values of the configuration
  localparam logic [SAMPLE_W-1:0] RST_MAX  = 16'd255;
  localparam logic [DEN_W-1:0]    RST_DEN  = 31'd7968750;
  localparam logic [HALF_W-1:0]   RST_HALF = 30'd3984375;

  typedef struct packed {
    logic        [SAMPLE_W-1:0] red_in;
    logic        [SAMPLE_W-1:0] green_in;
    logic        [SAMPLE_W-1:0] blue_in;
    logic signed [SAMPLE_W-1:0] luma_in;
    logic signed [SAMPLE_W-1:0] pb_in;
    logic signed [SAMPLE_W-1:0] pr_in;
  } rgbypb_in_t;

  typedef struct packed {
    logic        [SAMPLE_W-1:0] red_out;
    logic        [SAMPLE_W-1:0] green_out;
    logic        [SAMPLE_W-1:0] blue_out;
    logic signed [SAMPLE_W-1:0] luma_out;
    logic signed [SAMPLE_W-1:0] pb_out;
    logic signed [SAMPLE_W-1:0] pr_out;
  } rgbypb_out_t;

  typedef struct packed {
    logic                direction;
    logic [SAMPLE_W-1:0] max_sample;
    logic [DEN_W-1:0]    den;
    logic [HALF_W-1:0]   half;
  } cfg_t;

endpackage

### design/rgbypb_cfg.sv
// configuration registers: direction, full-scale sample and derived divisor terms
// depends on rgbypb_pkg
module rgbypb_cfg
  import rgbypb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t                cfg_r;
  cfg_t                cfg_nxt;
  logic [SAMPLE_W-1:0] dval;

  // zero full-scale behaves as one
  assign dval = (cfg_wdata == '0) ? SAMPLE_W'(1) : cfg_wdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DIRECTION: begin
          cfg_nxt.direction = cfg_wdata[0];
        end
        CFG_MAX_SAMPLE: begin
          cfg_nxt.max_sample = dval;
          cfg_nxt.den        = DEN_W'(dval) * DEN_MUL;
          cfg_nxt.half       = HALF_W'(dval) * HALF_MUL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.direction  <= DIR_FWD;
      cfg_r.max_sample <= RST_MAX;
      cfg_r.den        <= RST_DEN;
      cfg_r.half       <= RST_HALF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### design/rgbypb_fwd.sv
// forward path: bt.601 matrix, rounding and a pipelined restoring divider by the full-scale
// depends on rgbypb_pkg
module rgbypb_fwd
  import rgbypb_pkg::*;
(
  input  logic                               clk,
  input  logic [FWD_STAGES-1:0]              en,
  input  rgbypb_in_t                         in_data,
  input  cfg_t                               cfg,
  output logic [NCH-1:0][SAMPLE_W-1:0]       res
);

  logic signed [FWD_W-1:0] smp_x  [NCH];
  logic signed [FWD_W-1:0] prod_r [NCH][NCH];
  logic signed [FWD_W-1:0] sum_r  [NCH];
  logic        [FWD_W-1:0] mag    [NCH];
  logic        [REM_W-1:0] num_r  [NCH];
  logic                    neg2_r [NCH];
  logic        [REM_W-1:0] den_sh [QUO_W+1];
  logic        [REM_W-1:0] rem_r  [QUO_W+1][NCH];
  logic        [QUO_W-1:0] q_r    [QUO_W+1][NCH];
  logic                    negs_r [QUO_W+1][NCH];
  logic                    ovf_r  [QUO_W+1][NCH];
  logic        [SAMPLE_W-1:0] sat [NCH];
  logic        [SAMPLE_W-1:0] res_r [NCH];

  always_comb begin
    smp_x[0] = FWD_W'($signed({1'b0, in_data.red_in}));
    smp_x[1] = FWD_W'($signed({1'b0, in_data.green_in}));
    smp_x[2] = FWD_W'($signed({1'b0, in_data.blue_in}));
    for (int ch = 0; ch < NCH; ch++) begin
      mag[ch] = sum_r[ch][FWD_W-1] ? FWD_W'(-sum_r[ch]) : FWD_W'(sum_r[ch]);
    end
    // divisor aligned for each quotient bit; step 0 is the overflow check
    for (int j = 0; j <= QUO_W; j++) begin
      den_sh[j] = REM_W'(cfg.den) << (QUO_W - j);
    end
  end

  // saturate to signed 16 bits and apply the sign
  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      if (!negs_r[QUO_W][ch]) begin
        sat[ch] = (ovf_r[QUO_W][ch] || (q_r[QUO_W][ch] > SAT_POS)) ?
                  SAMPLE_W'(SAT_POS) : SAMPLE_W'(q_r[QUO_W][ch]);
      end else begin
        sat[ch] = (ovf_r[QUO_W][ch] || (q_r[QUO_W][ch] > SAT_NEG)) ?
                  SAMPLE_W'(SAT_NEG) : SAMPLE_W'(-q_r[QUO_W][ch]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int ch = 0; ch < NCH; ch++) begin
        for (int col = 0; col < NCH; col++) begin
          prod_r[ch][col] <= FWD_W'(FWD_COEF[ch][col]) * smp_x[col];
        end
      end
    end
    if (en[1]) begin
      for (int ch = 0; ch < NCH; ch++) begin
        sum_r[ch] <= prod_r[ch][0] + prod_r[ch][1] + prod_r[ch][2];
      end
    end
    if (en[2]) begin
      for (int ch = 0; ch < NCH; ch++) begin
        neg2_r[ch] <= sum_r[ch][FWD_W-1];
        num_r[ch]  <= (REM_W'(mag[ch]) << NUM_SHIFT) + REM_W'(cfg.half);
      end
    end
    if (en[DIV_FIRST-1]) begin
      for (int ch = 0; ch < NCH; ch++) begin
        negs_r[0][ch] <= neg2_r[ch];
        ovf_r[0][ch]  <= num_r[ch] >= den_sh[0];
        rem_r[0][ch]  <= num_r[ch];
        q_r[0][ch]    <= '0;
      end
    end
    // one quotient bit per stage, msb first
    for (int j = 1; j <= QUO_W; j++) begin
      if (en[DIV_FIRST-1+j]) begin
        for (int ch = 0; ch < NCH; ch++) begin
          negs_r[j][ch] <= negs_r[j-1][ch];
          ovf_r[j][ch]  <= ovf_r[j-1][ch];
          if (rem_r[j-1][ch] >= den_sh[j]) begin
            rem_r[j][ch] <= rem_r[j-1][ch] - den_sh[j];
            q_r[j][ch]   <= q_r[j-1][ch] | (QUO_W'(1) << (QUO_W - j));
          end else begin
            rem_r[j][ch] <= rem_r[j-1][ch];
            q_r[j][ch]   <= q_r[j-1][ch];
          end
        end
      end
    end
    if (en[FWD_STAGES-1]) begin
      for (int ch = 0; ch < NCH; ch++) begin
        res_r[ch] <= sat[ch];
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      res[ch] = res_r[ch];
    end
  end

endmodule

### design/rgbypb_rev.sv
// reverse path: inverse matrix, clamp, scale by full-scale and reciprocal divide
// depends on rgbypb_pkg
module rgbypb_rev
  import rgbypb_pkg::*;
(
  input  logic                         clk,
  input  logic [FWD_STAGES-1:0]        en,
  input  rgbypb_in_t                   in_data,
  input  cfg_t                         cfg,
  output logic [NCH-1:0][SAMPLE_W-1:0] res
);

  logic signed [REV_W-1:0]  y_x;
  logic signed [REV_W-1:0]  pb_x;
  logic signed [REV_W-1:0]  pr_x;
  logic signed [REV_W-1:0]  ys_r;
  logic signed [REV_W-1:0]  rv_r;
  logic signed [REV_W-1:0]  gu_r;
  logic signed [REV_W-1:0]  gv_r;
  logic signed [REV_W-1:0]  bu_r;
  logic signed [REV_W-1:0]  acc   [NCH];
  logic        [CLAMP_W-1:0] clmp [NCH];
  logic        [CLAMP_W-1:0] clmp_r [NCH];
  logic        [SCL_W-1:0]  scl   [NCH];
  logic        [X_W-1:0]    x_r   [NCH];
  logic        [RCP_W-1:0]  rcp   [NCH];
  logic        [SAMPLE_W-1:0] dly_r [DLY_N][NCH];

  assign y_x  = REV_W'(in_data.luma_in);
  assign pb_x = REV_W'(in_data.pb_in);
  assign pr_x = REV_W'(in_data.pr_in);

  always_comb begin
    acc[0] = ys_r + rv_r;
    acc[1] = ys_r - gu_r - gv_r;
    acc[2] = ys_r + bu_r;
    for (int ch = 0; ch < NCH; ch++) begin
      // clamp to [0, one] in the 1e6 * q1.14 domain
      if (acc[ch][REV_W-1]) begin
        clmp[ch] = '0;
      end else if (acc[ch][REV_W-2:0] > (REV_W-1)'(FULL_SCALE)) begin
        clmp[ch] = FULL_SCALE;
      end else begin
        clmp[ch] = CLAMP_W'(acc[ch]);
      end
      scl[ch] = SCL_W'(clmp_r[ch]) * SCL_W'(cfg.max_sample);
      rcp[ch] = RCP_W'(x_r[ch]) * RECIP;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ys_r <= y_x  * REV_W'(K_Y);
      rv_r <= pr_x * REV_W'(K_RV);
      gu_r <= pb_x * REV_W'(K_GU);
      gv_r <= pr_x * REV_W'(K_GV);
      bu_r <= pb_x * REV_W'(K_BU);
    end
    if (en[1]) begin
      for (int ch = 0; ch < NCH; ch++) begin
        clmp_r[ch] <= clmp[ch];
      end
    end
    if (en[2]) begin
      for (int ch = 0; ch < NCH; ch++) begin
        x_r[ch] <= scl[ch][PRE_SHIFT+X_W-1:PRE_SHIFT];
      end
    end
    if (en[REV_CORE-1]) begin
      for (int ch = 0; ch < NCH; ch++) begin
        dly_r[0][ch] <= rcp[ch][RECIP_SHIFT+SAMPLE_W-1:RECIP_SHIFT];
      end
    end
    // align with the forward path
    for (int i = 1; i < DLY_N; i++) begin
      if (en[REV_CORE-1+i]) begin
        for (int ch = 0; ch < NCH; ch++) begin
          dly_r[i][ch] <= dly_r[i-1][ch];
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      res[ch] = dly_r[DLY_N-1][ch];
    end
  end

endmodule

### design/rgb_ypbpr_converter_core.sv
// top level of the bt.601 rgb <-> ypbpr converter: stage valid/stall control and output register
// depends on rgbypb_pkg, rgbypb_cfg, rgbypb_fwd, rgbypb_rev
//
// usage
//   in_valid/in_stall/in_data carry one pixel per transaction; out_valid/out_stall/out_data
//   carry one converted pixel per transaction, in the same order, one result per pixel
//   direction 0: rgb samples in, luma/pb/pr q1.14 out (rgb outputs read zero)
//   direction 1: luma/pb/pr q1.14 in, rgb samples out (luma/pb/pr outputs read zero)
//   cfg_we/cfg_idx/cfg_wdata write direction (index 0) or max_sample (index 1), only while
//   the pipeline is empty; a zero max_sample acts as one
// timing
//   23 register stages, the last of which is the output register
//   one pixel per clock sustained while out_stall is low: every stage takes a new transaction each cycle
//   depth is set by the forward divide, a restoring divider with one quotient bit per stage
// reset and stall
//   reset empties the pipeline and loads direction 0, max_sample 255
//   when out_stall holds a result, stages behind it keep filling bubbles, and in_stall rises
//   only once every stage is occupied; nothing is dropped or repeated
module rgb_ypbpr_converter_core
  import rgbypb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rgbypb_in_t            in_data,
  // result output
  output logic                  out_valid,
  input  logic                  out_stall,
  output rgbypb_out_t           out_data,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t                         cfg;
  logic [NSTG-1:0]              en;
  logic [NSTG-1:0]              vld_r;
  logic [NSTG-1:0]              vld_nxt;
  logic [NCH-1:0][SAMPLE_W-1:0] fwd_res;
  logic [NCH-1:0][SAMPLE_W-1:0] rev_res;
  rgbypb_out_t                  out_data_r;
  rgbypb_out_t                  out_data_nxt;

  rgbypb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // a stage may load when the output drains or any stage at or after it holds a bubble
  for (genvar i = 0; i < NSTG; i++) begin : g_en
    assign en[i] = !out_stall || !(&vld_r[NSTG-1:i]);
  end

  assign in_stall = !en[0];

  rgbypb_fwd u_fwd (
    .clk     (clk),
    .en      (en[FWD_STAGES-1:0]),
    .in_data (in_data),
    .cfg     (cfg),
    .res     (fwd_res)
  );

  rgbypb_rev u_rev (
    .clk     (clk),
    .en      (en[FWD_STAGES-1:0]),
    .in_data (in_data),
    .cfg     (cfg),
    .res     (rev_res)
  );

  // valid bits move with the data; a stage that does not load keeps its transaction
  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int i = 1; i < NSTG; i++) begin
      if (en[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  // pick the active direction; the other outputs read zero
  always_comb begin
    out_data_nxt = '0;
    unique case (cfg.direction)
      DIR_FWD: begin
        out_data_nxt.luma_out = fwd_res[0];
        out_data_nxt.pb_out   = fwd_res[1];
        out_data_nxt.pr_out   = fwd_res[2];
      end
      DIR_REV: begin
        out_data_nxt.red_out   = rev_res[0];
        out_data_nxt.green_out = rev_res[1];
        out_data_nxt.blue_out  = rev_res[2];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // output register, payload only
  always_ff @(posedge clk) begin
    if (en[NSTG-1]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = vld_r[NSTG-1];
  assign out_data  = out_data_r;

endmodule

### test/tb_top.sv
// self-checking testbench for rgb_ypbpr_converter_core: bt.601 forward and reverse conversion
// depends on rgbypb_pkg for the payload structs and register indexes, and on the core rtl
module tb_top;
  import rgbypb_pkg::*;

  // quiet cycles tolerated before the run is declared hung
  localparam int HANG_LIMIT  = 2000;
  // pipeline depth named at the head of the core, plus margin
  localparam int DRAIN_WAIT  = 30;
  localparam int RAND_PHASES = 14;
  localparam int PHASE_ITEMS = 100;

  // fixed point of the predictor: coefficients scaled by 1e6, q1.14 unit
  localparam longint COEF_ONE = 1000000;
  localparam longint Q14_ONE  = 16384;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  rgbypb_in_t            in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  rgbypb_out_t           out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // pixels waiting for the driver, and converted pixels waiting for the monitor
  rgbypb_in_t  pixel_backlog[$];
  rgbypb_out_t converted_queue[$];

  // predictor copy of the configuration, starts at the reset values
  logic        conv_dir  = DIR_FWD;
  logic [15:0] conv_full = 16'd255;

  int error_count = 0;
  int quiet_cycles = 0;

  // handshake pacing state
  int in_gap = 0;
  int out_hold = 0;
  int out_draw;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;

  always #5 clk = ~clk;

  rgb_ypbpr_converter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // weighted sum of normalized samples to q1.14, rounded half away from zero, saturated
  function automatic logic [15:0] q14_term(longint weighted, longint full);
    longint num;
    longint den;
    longint q;
    num = weighted * Q14_ONE;
    den = COEF_ONE * full;
    if (num >= 0) q = (num + den / 2) / den;
    else q = -((-num + den / 2) / den);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // reverse channel: clamp to [0, 1.0], rescale to full scale, truncate
  function automatic logic [15:0] rgb_term(longint acc, longint full);
    longint one;
    longint scaled;
    one = COEF_ONE * Q14_ONE;
    if (acc < 0) acc = 0;
    if (acc > one) acc = one;
    scaled = (acc * full) / one;
    return scaled[15:0];
  endfunction

  // expected converted pixel for the current direction and full scale
  function automatic rgbypb_out_t convert_pixel(rgbypb_in_t px, logic dir, logic [15:0] fs);
    rgbypb_out_t res;
    longint full;
    longint r, g, b;
    longint y, pb, pr;
    res = '0;
    // a zero full scale behaves as one
    full = (fs == 16'd0) ? 1 : longint'(fs);
    if (dir == DIR_FWD) begin
      r = longint'(px.red_in);
      g = longint'(px.green_in);
      b = longint'(px.blue_in);
      res.luma_out = q14_term(299000 * r + 587000 * g + 114000 * b, full);
      res.pb_out   = q14_term(-168736 * r - 331264 * g + 500000 * b, full);
      res.pr_out   = q14_term(500000 * r - 418688 * g - 81312 * b, full);
    end else begin
      y  = longint'($signed(px.luma_in)) * COEF_ONE;
      pb = longint'($signed(px.pb_in));
      pr = longint'($signed(px.pr_in));
      res.red_out   = rgb_term(y + 1402000 * pr, full);
      res.green_out = rgb_term(y - 344136 * pb - 714136 * pr, full);
      res.blue_out  = rgb_term(y + 1772000 * pb, full);
    end
    return res;
  endfunction

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  // register write; the predictor copy follows the same write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_DIRECTION) conv_dir = value[0];
    else conv_full = value;
  endtask

  // direction write with junk in the unused upper bits
  task automatic write_dir(logic dir);
    logic [CFG_DATA_W-1:0] value;
    value = CFG_DATA_W'($urandom);
    value[0] = dir;
    write_reg(CFG_DIRECTION, value);
  endtask

  // rgb pixel; the ypbpr fields carry noise that forward mode ignores
  task automatic queue_rgb(logic [15:0] r, logic [15:0] g, logic [15:0] b);
    rgbypb_in_t px;
    px = {$urandom, $urandom, $urandom};
    px.red_in   = r;
    px.green_in = g;
    px.blue_in  = b;
    pixel_backlog.push_back(px);
  endtask

  // ypbpr pixel; the rgb fields carry noise that reverse mode ignores
  task automatic queue_ypbpr(logic [15:0] y, logic [15:0] pb, logic [15:0] pr);
    rgbypb_in_t px;
    px = {$urandom, $urandom, $urandom};
    px.luma_in = y;
    px.pb_in   = pb;
    px.pr_in   = pr;
    pixel_backlog.push_back(px);
  endtask

  // random pixel: mostly in range for the mode, the rest raw noise on every field
  task automatic queue_random(logic dir, logic [15:0] fs);
    rgbypb_in_t px;
    int top;
    px = {$urandom, $urandom, $urandom};
    top = (fs == 16'd0) ? 1 : int'(fs);
    if ($urandom_range(0, 99) < 85) begin
      if (dir == DIR_FWD) begin
        px.red_in   = 16'($urandom_range(0, top));
        px.green_in = 16'($urandom_range(0, top));
        px.blue_in  = 16'($urandom_range(0, top));
      end else begin
        // luma in [0, 1.0], color differences in [-0.5, 0.5]
        px.luma_in = 16'($urandom_range(0, 16384));
        px.pb_in   = 16'(int'($urandom_range(0, 16384)) - 8192);
        px.pr_in   = 16'(int'($urandom_range(0, 16384)) - 8192);
      end
    end
    pixel_backlog.push_back(px);
  endtask

  // wait until every queued pixel has gone in and every conversion has come out
  task automatic wait_drained();
    do @(negedge clk);
    while (pixel_backlog.size() != 0 || in_valid || converted_queue.size() != 0);
  endtask

  // driver: one pixel per transaction, random gap after each, occasional back-to-back bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (!(in_valid && in_stall)) begin
      // a pixel presented here was accepted at this edge
      if (in_valid) begin
        converted_queue.push_back(convert_pixel(in_data, conv_dir, conv_full));
      end
      if (in_gap != 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pixel_backlog.size() != 0) begin
        in_data  <= pixel_backlog.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 31) == 0) in_burst = !in_burst;
        in_gap   <= in_burst ? 0 : int'($urandom_range(0, 19));
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks each result transaction against the oldest prediction, then stalls a while
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold  <= 0;
    end else if (out_valid && !out_stall) begin
      if (converted_queue.size() == 0) begin
        $error("result transaction with no conversion outstanding");
        error_count++;
      end else begin
        rgbypb_out_t want;
        want = converted_queue.pop_front();
        compare_field("red_out", int'(want.red_out), int'(out_data.red_out));
        compare_field("green_out", int'(want.green_out), int'(out_data.green_out));
        compare_field("blue_out", int'(want.blue_out), int'(out_data.blue_out));
        compare_field("luma_out", int'($signed(want.luma_out)),
                      int'($signed(out_data.luma_out)));
        compare_field("pb_out", int'($signed(want.pb_out)), int'($signed(out_data.pb_out)));
        compare_field("pr_out", int'($signed(want.pr_out)), int'($signed(out_data.pr_out)));
      end
      if ($urandom_range(0, 31) == 0) out_burst = !out_burst;
      out_draw = out_burst ? 0 : int'($urandom_range(0, 19));
      out_hold  <= out_draw;
      out_stall <= (out_draw != 0);
    end else if (out_valid && out_hold != 0) begin
      // stall only counts down against a waiting result
      out_hold  <= out_hold - 1;
      out_stall <= (out_hold > 1);
    end
  end

  // watchdog: too long without any transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("rgb_ypbpr_converter_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic        dir;
    logic [15:0] fs;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset configuration: forward, full scale 255; primaries, white, over-range samples
    @(negedge clk);
    queue_rgb(16'd0, 16'd0, 16'd0);
    queue_rgb(16'd255, 16'd255, 16'd255);
    queue_rgb(16'd255, 16'd0, 16'd0);
    queue_rgb(16'd0, 16'd255, 16'd0);
    queue_rgb(16'd0, 16'd0, 16'd255);
    queue_rgb(16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_rgb(16'hFFFF, 16'd0, 16'd0);
    wait_drained();

    // zero full scale acts as one
    write_reg(CFG_MAX_SAMPLE, 16'd0);
    @(negedge clk);
    queue_rgb(16'd1, 16'd1, 16'd1);
    queue_rgb(16'd1, 16'd0, 16'd1);
    queue_rgb(16'd0, 16'd0, 16'd0);
    wait_drained();

    // reverse at the widest full scale: black, white, clamping at both rails
    write_dir(DIR_REV);
    write_reg(CFG_MAX_SAMPLE, 16'hFFFF);
    @(negedge clk);
    queue_ypbpr(16'd0, 16'd0, 16'd0);
    queue_ypbpr(16'd16384, 16'd0, 16'd0);
    queue_ypbpr(16'h7FFF, 16'h7FFF, 16'h7FFF);
    queue_ypbpr(16'h8000, 16'h8000, 16'h8000);
    queue_ypbpr(16'd16384, -16'sd8192, 16'd8192);
    queue_ypbpr(16'd8192, 16'd8192, -16'sd8192);
    queue_ypbpr(16'h7FFF, 16'h8000, 16'h7FFF);
    queue_ypbpr(16'd0, 16'h7FFF, 16'h8000);
    wait_drained();

    // reverse at full scale one: truncation just below and at 1.0
    write_reg(CFG_MAX_SAMPLE, 16'd1);
    @(negedge clk);
    queue_ypbpr(16'd16384, 16'd0, 16'd0);
    queue_ypbpr(16'd16383, 16'd0, 16'd0);
    queue_ypbpr(16'hFFFF, 16'd0, 16'd0);
    wait_drained();

    // forward at the widest full scale
    write_dir(DIR_FWD);
    write_reg(CFG_MAX_SAMPLE, 16'hFFFF);
    @(negedge clk);
    queue_rgb(16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_rgb(16'hFFFF, 16'd0, 16'hFFFF);
    queue_rgb(16'h8000, 16'h8000, 16'd0);
    wait_drained();

    // random phases, each with a fresh direction and full scale
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      dir = (ph < 2) ? ph[0] : 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0: fs = 16'd1;
        1: fs = 16'hFFFF;
        2: fs = 16'd255;
        3: fs = 16'd1023;
        4: fs = 16'($urandom_range(1, 65535));
        default: fs = 16'd0;
      endcase
      write_dir(dir);
      write_reg(CFG_MAX_SAMPLE, fs);
      @(negedge clk);
      for (int k = 0; k < PHASE_ITEMS; k++) queue_random(dir, fs);
      wait_drained();
    end

    // let anything still in the pipeline surface before the verdict
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0 && converted_queue.size() == 0) begin
      $display("rgb_ypbpr_converter_core regression: pass");
    end else begin
      $display("rgb_ypbpr_converter_core regression: fail");
    end
    $finish;
  end

endmodule
